### src/bdq_pkg.sv
// ============================================================================
// bdq_pkg
// shared types and codes for the bounded deque engine
// ============================================================================
`default_nettype none

package bdq_pkg;

    localparam int unsigned DATA_W = 32;

    // operation codes carried on the input tuser
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST       = 3'd4
    } t_op;

    // result status carried on the output tuser
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    // what every cell of the chain does at each clock edge
    typedef enum logic [2:0] {
        CM_HOLD    = 3'd0,
        CM_SHR     = 3'd1,
        CM_WR_BACK = 3'd2,
        CM_SHL     = 3'd3,
        CM_ROT     = 3'd4
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode          mode;
        logic [DATA_W-1:0]   push_data;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LIST = 1'b1
    } t_state;

endpackage

`default_nettype wire

### src/bdq_cell.sv
// ============================================================================
// bdq_cell
// one entry of the deque chain, shifts toward either neighbor
// ============================================================================
`default_nettype none

module bdq_cell #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0
) (
    input  wire logic                             i_clk,
    input  wire bdq_pkg::t_cell_ctl               i_ctl,
    input  wire logic [$clog2(DEPTH+1)-1:0]       i_count,
    input  wire logic [bdq_pkg::DATA_W-1:0]       i_left,
    input  wire logic [bdq_pkg::DATA_W-1:0]       i_right,
    input  wire logic [bdq_pkg::DATA_W-1:0]       i_head,
    output logic      [bdq_pkg::DATA_W-1:0]       o_data,
    output logic      [bdq_pkg::DATA_W-1:0]       o_tail
);
    import bdq_pkg::*;

    localparam int CW = $clog2(DEPTH+1);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_is_tail;
    logic              w_is_free;

    assign w_is_tail = (i_count == CW'(IDX + 1));
    assign w_is_free = (i_count == CW'(IDX));

    always_comb begin
        n_data = r_data;
        case (i_ctl.mode)
            CM_SHR:     n_data = i_left;
            CM_WR_BACK: if (w_is_free) begin
                n_data = i_ctl.push_data;
            end
            CM_SHL:     n_data = i_right;
            CM_ROT:     n_data = w_is_tail ? i_head : i_right;
            default:    n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tail = w_is_tail ? r_data : '0;

endmodule

`default_nettype wire

### src/bounded_deque_engine.sv
// ============================================================================
// bounded_deque_engine
// bounded double-ended queue of signed 32-bit words in a chain of cells
// ============================================================================
// The deque lives in a row of DEPTH cells with the front entry always in
// cell 0; an entry count marks how many cells are held. Push front shifts
// the whole row one cell back and loads the new word into cell 0, push back
// writes the first free cell, pop front shifts the row toward cell 0 and
// pop back reads the last held cell. A push, a pop or an unused operation
// code is done when accepted, so such words are accepted one per cycle as
// long as the output register is free or being drained. A list is taken,
// then runs one step per held entry: each step emits cell 0 and rotates
// the held part of the row by one, so after count steps the row is back
// in order; no input is taken during those steps. Listing an empty deque,
// popping an empty one or pushing a full one gives a single result with
// the empty or full status and a zero value. Every result carries tlast
// on the final word of its operation. No clearing pass after reset.
`default_nettype none

module bounded_deque_engine #(
    parameter int DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] value_in
    input  wire logic [2:0]  i_s_tuser,   // [2:0] func
    // output stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [31:0] o_m_tdata,   // [31:0] value_out
    output logic      [1:0]  o_m_tuser,   // [1:0] status
    output logic             o_m_tlast    // last result of the operation
);
    import bdq_pkg::*;

    localparam int CW = $clog2(DEPTH+1);

    // control state
    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [CW-1:0]     r_left;     // list words still to emit
    logic [CW-1:0]     n_left;

    // output register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    t_status           r_out_status;
    logic              r_out_last;

    // load request for the output register
    logic              w_load;
    logic [DATA_W-1:0] w_ld_data;
    t_status           w_ld_status;
    logic              w_ld_last;

    logic              w_out_free;
    logic              w_in_acc;
    logic              w_full;
    logic              w_empty;
    t_op               w_op;
    t_cell_ctl         w_ctl;

    // cell chain taps
    logic [DATA_W-1:0] w_cell [DEPTH];
    logic [DATA_W-1:0] w_tail [DEPTH];
    logic [DATA_W-1:0] w_tail_data;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_op       = t_op'(i_s_tuser);

    // only the last held cell drives its tail tap
    always_comb begin
        w_tail_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_tail_data = w_tail_data | w_tail[i];
        end
    end

    // the chain: cell 0 takes the pushed word on a right shift
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bdq_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_left  ((g == 0) ? i_s_tdata : w_cell[(g == 0) ? 0 : g-1]),
            .i_right (w_cell[(g == DEPTH-1) ? g : g+1]),
            .i_head  (w_cell[0]),
            .o_data  (w_cell[g]),
            .o_tail  (w_tail[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_acc && w_op == OP_LIST && !w_empty) begin
                n_state = ST_LIST;
            end
            ST_LIST: if (w_out_free && r_left == CW'(1)) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath control and result selection
    always_comb begin
        w_ctl.mode      = CM_HOLD;
        w_ctl.push_data = i_s_tdata;
        n_count         = r_count;
        n_left          = r_left;
        w_load          = 1'b0;
        w_ld_data       = '0;
        w_ld_status     = STS_OK;
        w_ld_last       = 1'b1;
        if (w_in_acc) begin
            case (w_op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    w_load = 1'b1;
                    if (w_full) begin
                        w_ld_status = STS_FULL;
                    end else begin
                        w_ctl.mode = (w_op == OP_PUSH_FRONT) ? CM_SHR : CM_WR_BACK;
                        n_count    = r_count + CW'(1);
                    end
                end
                OP_POP_FRONT, OP_POP_BACK: begin
                    w_load = 1'b1;
                    if (w_empty) begin
                        w_ld_status = STS_EMPTY;
                    end else begin
                        n_count = r_count - CW'(1);
                        if (w_op == OP_POP_FRONT) begin
                            w_ctl.mode = CM_SHL;
                            w_ld_data  = w_cell[0];
                        end else begin
                            w_ld_data  = w_tail_data;
                        end
                    end
                end
                OP_LIST: begin
                    if (w_empty) begin
                        w_load      = 1'b1;
                        w_ld_status = STS_EMPTY;
                    end else begin
                        n_left = r_count;
                    end
                end
                default: begin
                    // unused codes are dropped without a result
                    w_load = 1'b0;
                end
            endcase
        end else if (r_state == ST_LIST && w_out_free) begin
            // emit the front and rotate the held part of the chain
            w_load     = 1'b1;
            w_ld_data  = w_cell[0];
            w_ld_last  = (r_left == CW'(1));
            w_ctl.mode = CM_ROT;
            n_left     = r_left - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data   <= w_ld_data;
            r_out_status <= w_ld_status;
            r_out_last   <= w_ld_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

    // entry count never passes the chain length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // no input is taken while a list is being emitted
    a_list_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LIST |-> !o_s_tready)
        else $error("input accepted during list");

    // the final list step returns to idle with tlast on its word
    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIST && w_out_free && r_left == CW'(1))
        |=> (r_state == ST_IDLE && o_m_tvalid && o_m_tlast))
        else $error("list did not end cleanly");

    // a push to a full deque leaves the count alone
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_full && (w_op == OP_PUSH_FRONT || w_op == OP_PUSH_BACK))
        |=> $stable(r_count))
        else $error("dropped push changed count");

endmodule

`default_nettype wire
